// ===== sv/mvpm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvpm_pkg
// Shared widths, request and status codes, and the command and status
// structs that join the mixer controller to its datapath.
// ----------------------------------------------------------------------------
package mvpm_pkg;

  // Field widths fixed by the request and result formats.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned ADDR_IN_W = 16;
  localparam int unsigned FRAMES_W  = 17;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned VOICES_W  = 5;

  // Request codes.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_STOP  = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Limits applied to start requests.
  localparam logic [FRAMES_W-1:0] MAX_LENGTH = 17'h10000;
  localparam logic [GAIN_W-1:0]   UNITY_GAIN = 16'h8000;

  // Saturation bounds of the mix.
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic red_start;
    logic idx_clr;
    logic idx_step;
    logic scan_step;
    logic mem_write;
    logic slot_write;
    logic tick_clr;
    logic tick_issue;
    logic stop_all;
    logic out_load;
  } mvpm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_type;
    logic       red_done;
    logic       idx_last_eff;
    logic       idx_last_slot;
    logic       pipe_empty;
  } mvpm_stat_t;

endpackage

// ===== sv/mvpm_if.sv =====
// ----------------------------------------------------------------------------
// mvpm_if
// Valid/ready channels of the mixer: the request channel and the result
// channel. A beat moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface mvpm_req_if import mvpm_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [ADDR_IN_W-1:0]        mem_addr;
  logic signed [SAMPLE_W-1:0]  load_left;
  logic signed [SAMPLE_W-1:0]  load_right;
  logic [FRAMES_W-1:0]         sound_frames;
  logic [GAIN_W-1:0]           gain;
  logic                        repeat_flag;
  logic                        music_slot;

  modport source (
    output valid, req_type, mem_addr, load_left, load_right, sound_frames,
           gain, repeat_flag, music_slot,
    input  ready
  );
  modport sink (
    input  valid, req_type, mem_addr, load_left, load_right, sound_frames,
           gain, repeat_flag, music_slot,
    output ready
  );
endinterface

interface mvpm_res_if import mvpm_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  mix_left;
  logic signed [SAMPLE_W-1:0]  mix_right;
  logic [STATUS_W-1:0]         status;
  logic [VOICES_W-1:0]         active_voices;

  modport source (
    output valid, mix_left, mix_right, status, active_voices,
    input  ready
  );
  modport sink (
    input  valid, mix_left, mix_right, status, active_voices,
    output ready
  );
endinterface

// ===== sv/mvpm_addr_mod.sv =====
// ----------------------------------------------------------------------------
// mvpm_addr_mod
// Reduces a 16-bit frame address modulo the sample memory depth with a
// constant reciprocal multiply, then one multiply-subtract.
// ----------------------------------------------------------------------------
module mvpm_addr_mod import mvpm_pkg::*; #(
  parameter int unsigned SAMPLE_FRAMES = 65536
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [ADDR_IN_W-1:0]                 value_i,
  output logic                                 done_o,
  output logic [$clog2(SAMPLE_FRAMES)-1:0]     rem_o
);

  localparam int unsigned AW = $clog2(SAMPLE_FRAMES);
  // The depth is at least 256, so a 16-bit address has a quotient below 256.
  localparam int unsigned QW = 8;
  // With K = 16 + ceil(log2(depth)) and the reciprocal rounded up, the
  // product with any 16-bit address gives the exact quotient.
  localparam int unsigned K  = ADDR_IN_W + AW;
  localparam int unsigned MW = ADDR_IN_W + 2;
  localparam int unsigned PW = ADDR_IN_W + MW;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << K) + 64'(SAMPLE_FRAMES) - 64'd1) / 64'(SAMPLE_FRAMES);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_FULL);
  // Depths above the address range always give a zero quotient, so only
  // the low bits of the divisor matter.
  localparam logic [ADDR_IN_W-1:0] DIV_LO = ADDR_IN_W'(SAMPLE_FRAMES);

  logic [ADDR_IN_W-1:0]    val_q;
  logic [QW-1:0]           quot_q;
  logic [AW-1:0]           rem_q;
  logic                    busy_q;
  logic                    phase_q;
  logic [PW-1:0]           prod;
  logic [ADDR_IN_W+QW-1:0] qd;

  assign prod = {{MW{1'b0}}, val_q} * {{ADDR_IN_W{1'b0}}, RECIP};
  assign qd   = {{QW{1'b0}}, DIV_LO} * {{ADDR_IN_W{1'b0}}, quot_q};

  // Step control: quotient phase first, then the remainder phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      phase_q <= 1'b0;
    end else if (busy_q) begin
      if (phase_q) begin
        busy_q <= 1'b0;
      end else begin
        phase_q <= 1'b1;
      end
    end
  end

  // Operand, quotient and remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
    end else if (busy_q && !phase_q) begin
      quot_q <= QW'(prod >> K);
    end else if (busy_q && phase_q) begin
      rem_q <= AW'(val_q - qd[ADDR_IN_W-1:0]);
    end
  end

  assign done_o = !busy_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/mvpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mvpm_ctrl
// Request sequencer of the mixer: accepts a request, steps the datapath
// through it and hands the result to the output register.
// ----------------------------------------------------------------------------
module mvpm_ctrl import mvpm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  mvpm_stat_t stat_i,
  output mvpm_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_RED_WAIT = 3'd2;
  localparam logic [2:0] S_START_WR = 3'd3;
  localparam logic [2:0] S_TICK     = 3'd4;
  localparam logic [2:0] S_DRAIN    = 3'd5;
  localparam logic [2:0] S_STOP     = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture   = 1'b1;
          cmd_o.red_start = 1'b1;
          cmd_o.idx_clr   = 1'b1;
          cmd_o.tick_clr  = 1'b1;
          unique case (req_type_i)
            REQ_LOAD:  state_d = S_RED_WAIT;
            REQ_START: state_d = S_SCAN;
            REQ_TICK:  state_d = S_TICK;
            default:   state_d = S_STOP;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.idx_step  = 1'b1;
        if (stat_i.idx_last_eff) begin
          state_d = S_RED_WAIT;
        end
      end
      S_RED_WAIT: begin
        if (stat_i.red_done) begin
          if (stat_i.req_type == REQ_LOAD) begin
            cmd_o.mem_write = 1'b1;
            state_d         = S_DONE;
          end else begin
            state_d = S_START_WR;
          end
        end
      end
      S_START_WR: begin
        cmd_o.slot_write = 1'b1;
        state_d          = S_DONE;
      end
      S_TICK: begin
        cmd_o.tick_issue = 1'b1;
        cmd_o.idx_step   = 1'b1;
        if (stat_i.idx_last_slot) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat_i.pipe_empty) begin
          state_d = S_DONE;
        end
      end
      S_STOP: begin
        cmd_o.stop_all = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output beat valid: set on load, cleared once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_o.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/mvpm_datapath.sv =====
// ----------------------------------------------------------------------------
// mvpm_datapath
// Sample memory, voice slot registers, the per-slot scale and accumulate
// pipeline, and the result register of the mixer.
// ----------------------------------------------------------------------------
module mvpm_datapath import mvpm_pkg::*; #(
  parameter int unsigned MAX_EFFECTS   = 16,
  parameter int unsigned SAMPLE_FRAMES = 65536
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mvpm_cmd_t                   cmd_i,
  output mvpm_stat_t                  stat_o,
  input  logic [1:0]                  req_type_i,
  input  logic [ADDR_IN_W-1:0]        mem_addr_i,
  input  logic signed [SAMPLE_W-1:0]  load_left_i,
  input  logic signed [SAMPLE_W-1:0]  load_right_i,
  input  logic [FRAMES_W-1:0]         sound_frames_i,
  input  logic [GAIN_W-1:0]           gain_i,
  input  logic                        repeat_flag_i,
  input  logic                        music_slot_i,
  output logic signed [SAMPLE_W-1:0]  mix_left_o,
  output logic signed [SAMPLE_W-1:0]  mix_right_o,
  output logic [STATUS_W-1:0]         status_o,
  output logic [VOICES_W-1:0]         active_voices_o
);

  localparam int unsigned SLOTS  = MAX_EFFECTS + 1;
  localparam int unsigned AW     = $clog2(SAMPLE_FRAMES);
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned SC_W   = PROD_W - 15;
  localparam int unsigned ACC_W  = SC_W + $clog2(SLOTS);
  localparam logic [IDX_W-1:0] MUSIC_IDX    = IDX_W'(MAX_EFFECTS);
  localparam logic [IDX_W-1:0] LAST_EFF_IDX = IDX_W'(MAX_EFFECTS - 1);
  localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(SLOTS - 1);
  localparam logic [AW:0]      DEPTH        = (AW + 1)'(SAMPLE_FRAMES);

  // Captured request.
  logic [1:0]                 rtype_q;
  logic signed [SAMPLE_W-1:0] left_q, right_q;
  logic [FRAMES_W-1:0]        frames_q;
  logic [GAIN_W-1:0]          gain_q;
  logic                       rep_q, music_q;
  logic [STATUS_W-1:0]        st_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rtype_q  <= req_type_i;
      left_q   <= load_left_i;
      right_q  <= load_right_i;
      frames_q <= (sound_frames_i > MAX_LENGTH) ? MAX_LENGTH : sound_frames_i;
      gain_q   <= (gain_i > UNITY_GAIN) ? UNITY_GAIN : gain_i;
      rep_q    <= repeat_flag_i;
      music_q  <= music_slot_i;
    end
  end

  // Address reduction unit.
  logic          red_done;
  logic [AW-1:0] red_rem;

  mvpm_addr_mod #(
    .SAMPLE_FRAMES(SAMPLE_FRAMES)
  ) u_addr_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.red_start),
    .value_i(mem_addr_i),
    .done_o (red_done),
    .rem_o  (red_rem)
  );

  // Slot index counter, shared by the free-slot scan and the tick sweep.
  logic [IDX_W-1:0] idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_step) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Slot state.
  logic                   active_q [SLOTS];
  logic [AW-1:0]          rbase_q  [SLOTS];
  logic [AW-1:0]          addr_q   [SLOTS];
  logic [FRAMES_W-1:0]    len_q    [SLOTS];
  logic [FRAMES_W-2:0]    pos_q    [SLOTS];
  logic [GAIN_W-1:0]      sgain_q  [SLOTS];
  logic                   srep_q   [SLOTS];
  logic [CNT_W-1:0]       count_q;

  // First free effect slot, found one index per cycle.
  logic             found_q;
  logic [IDX_W-1:0] free_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      free_idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan_step && !found_q && !active_q[idx_q]) begin
      found_q    <= 1'b1;
      free_idx_q <= idx_q;
    end
  end

  // Start decode.
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [STATUS_W-1:0] st_d;

  always_comb begin
    wr_idx = music_q ? MUSIC_IDX : free_idx_q;
    wr_en  = cmd_i.slot_write && (frames_q != '0) && (music_q || found_q);
    if (frames_q == '0) begin
      st_d = STATUS_EMPTY;
    end else if (!music_q && !found_q) begin
      st_d = STATUS_FULL;
    end else begin
      st_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      st_q <= STATUS_OK;
    end else if (cmd_i.slot_write) begin
      st_q <= st_d;
    end
  end

  // Tick advance of the slot under the sweep.
  logic            t_act, t_end, t_free;
  logic [FRAMES_W-1:0] pos_inc;
  logic [AW:0]     addr_inc;
  logic [AW-1:0]   addr_next;

  always_comb begin
    t_act     = cmd_i.tick_issue && active_q[idx_q];
    pos_inc   = {1'b0, pos_q[idx_q]} + 1'b1;
    t_end     = (pos_inc >= len_q[idx_q]);
    t_free    = t_act && t_end && !srep_q[idx_q];
    addr_inc  = {1'b0, addr_q[idx_q]} + 1'b1;
    addr_next = (addr_inc == DEPTH) ? '0 : addr_inc[AW-1:0];
  end

  // Active flags and the voice count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        active_q[i] <= 1'b0;
      end
      count_q <= '0;
    end else if (cmd_i.stop_all) begin
      for (int i = 0; i < SLOTS; i++) begin
        active_q[i] <= 1'b0;
      end
      count_q <= '0;
    end else if (wr_en) begin
      active_q[wr_idx] <= 1'b1;
      if (!active_q[wr_idx]) begin
        count_q <= count_q + 1'b1;
      end
    end else if (t_free) begin
      active_q[idx_q] <= 1'b0;
      count_q         <= count_q - 1'b1;
    end
  end

  // Slot fields.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rbase_q[wr_idx] <= red_rem;
      addr_q[wr_idx]  <= red_rem;
      len_q[wr_idx]   <= frames_q;
      pos_q[wr_idx]   <= '0;
      sgain_q[wr_idx] <= gain_q;
      srep_q[wr_idx]  <= rep_q;
    end else if (t_act) begin
      if (t_end) begin
        pos_q[idx_q]  <= '0;
        addr_q[idx_q] <= rbase_q[idx_q];
      end else begin
        pos_q[idx_q]  <= pos_inc[FRAMES_W-2:0];
        addr_q[idx_q] <= addr_next;
      end
    end
  end

  // Sample memory: right sample in the upper half, left in the lower half.
  logic [2*SAMPLE_W-1:0] mem [SAMPLE_FRAMES];
  logic [2*SAMPLE_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write) begin
      mem[red_rem] <= {right_q, left_q};
    end
    rd_q <= mem[addr_q[idx_q]];
  end

  // Pipeline valid flags.
  logic s1_v_q, s2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= t_act;
      s2_v_q <= s1_v_q;
    end
  end

  // Gain scaling products.
  logic [GAIN_W-1:0]         s1_gain_q;
  logic signed [PROD_W-1:0]  prod_l_q, prod_r_q;

  always_ff @(posedge clk_i) begin
    s1_gain_q <= sgain_q[idx_q];
    prod_l_q  <= PROD_W'($signed(rd_q[SAMPLE_W-1:0]) * $signed({1'b0, s1_gain_q}));
    prod_r_q  <= PROD_W'($signed(rd_q[2*SAMPLE_W-1:SAMPLE_W]) *
                         $signed({1'b0, s1_gain_q}));
  end

  // Shift right by 15 with truncation toward zero.
  function automatic logic signed [SC_W-1:0] scale_q15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    adj = p + (p[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));
    return adj[PROD_W-1:15];
  endfunction

  logic signed [SC_W-1:0]  sc_l, sc_r;
  logic signed [ACC_W-1:0] acc_l_q, acc_r_q;

  assign sc_l = scale_q15(prod_l_q);
  assign sc_r = scale_q15(prod_r_q);

  // Exact accumulation of the scaled slot samples.
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_clr) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (s2_v_q) begin
      acc_l_q <= acc_l_q + ACC_W'(sc_l);
      acc_r_q <= acc_r_q + ACC_W'(sc_r);
    end
  end

  // Saturate a channel sum to 16 bits.
  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (v < ACC_W'(SAT_MIN)) begin
      return SAT_MIN;
    end else begin
      return v[SAMPLE_W-1:0];
    end
  endfunction

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mix_left_o      <= (rtype_q == REQ_TICK) ? sat16(acc_l_q) : '0;
      mix_right_o     <= (rtype_q == REQ_TICK) ? sat16(acc_r_q) : '0;
      status_o        <= st_q;
      active_voices_o <= VOICES_W'(count_q);
    end
  end

  // Status toward the controller.
  assign stat_o.req_type      = rtype_q;
  assign stat_o.red_done      = red_done;
  assign stat_o.idx_last_eff  = (idx_q == LAST_EFF_IDX);
  assign stat_o.idx_last_slot = (idx_q == LAST_IDX);
  assign stat_o.pipe_empty    = !s1_v_q && !s2_v_q;

endmodule

// ===== sv/multi_voice_pcm_mixer.sv =====
// ----------------------------------------------------------------------------
// multi_voice_pcm_mixer
// Stereo PCM mixer with MAX_EFFECTS effect slots and one music slot.
// ----------------------------------------------------------------------------
// Requests arrive on in_i and each gives exactly one result beat on out_o.
// A request loads a stereo frame into sample memory, starts a sound in the
// first free effect slot or in the music slot, mixes one output frame on a
// tick, or stops all slots. One request is in work at a time.
// Steps from the accepted beat to the result beat:
//   load:  the address reduction unit, then the memory write.
//   start: the free-slot scan of one slot per cycle beside the address
//          reduction unit, then the slot write.
//   tick:  the sweep takes one slot per cycle through the
//          memory read, the gain multiply and the accumulator.
//   stop:  every slot is cleared at once.
// The result waits in an output register; a new request is taken while it
// waits, and a finished request holds only until that register is free.
// Reset clears every slot and the output valid; sample memory holds no
// defined value until it is written.
// ----------------------------------------------------------------------------
module multi_voice_pcm_mixer import mvpm_pkg::*; #(
  parameter int unsigned MAX_EFFECTS   = 16,
  parameter int unsigned SAMPLE_FRAMES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mvpm_req_if.sink    in_i,
  mvpm_res_if.source  out_o
);

  mvpm_cmd_t  cmd;
  mvpm_stat_t stat;

  // Controller.
  mvpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .req_type_i (in_i.req_type),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath.
  mvpm_datapath #(
    .MAX_EFFECTS  (MAX_EFFECTS),
    .SAMPLE_FRAMES(SAMPLE_FRAMES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_type_i     (in_i.req_type),
    .mem_addr_i     (in_i.mem_addr),
    .load_left_i    (in_i.load_left),
    .load_right_i   (in_i.load_right),
    .sound_frames_i (in_i.sound_frames),
    .gain_i         (in_i.gain),
    .repeat_flag_i  (in_i.repeat_flag),
    .music_slot_i   (in_i.music_slot),
    .mix_left_o     (out_o.mix_left),
    .mix_right_o    (out_o.mix_right),
    .status_o       (out_o.status),
    .active_voices_o(out_o.active_voices)
  );

endmodule

// ===== bench/multi_voice_pcm_mixer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_voice_pcm_mixer_tb
// Self-checking bench for the stereo PCM mixer. A behavioral copy of the
// voice slots and the sample memory predicts every result beat. A short
// directed pass covers the edge cases, and a long random pass with random
// idle gaps on both channels follows it. Frames are loaded before any tick
// reads them, so no read ever touches sample memory that was never written.
// ----------------------------------------------------------------------------
module multi_voice_pcm_mixer_tb;
  import mvpm_pkg::*;

  localparam int unsigned EFFECT_SLOTS = 16;
  localparam int unsigned FRAME_DEPTH  = 65536;
  localparam int unsigned MUSIC_SLOT   = EFFECT_SLOTS;
  localparam int unsigned VOICE_SLOTS  = EFFECT_SLOTS + 1;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [1:0]                 req_type;
    logic [ADDR_IN_W-1:0]       mem_addr;
    logic signed [SAMPLE_W-1:0] load_left;
    logic signed [SAMPLE_W-1:0] load_right;
    logic [FRAMES_W-1:0]        sound_frames;
    logic [GAIN_W-1:0]          gain;
    logic                       repeat_flag;
    logic                       music_slot;
  } mix_req_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] mix_left;
    logic signed [SAMPLE_W-1:0] mix_right;
    logic [STATUS_W-1:0]        status;
    logic [VOICES_W-1:0]        active_voices;
  } mix_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mvpm_req_if req_ch ();
  mvpm_res_if res_ch ();

  multi_voice_pcm_mixer #(
    .MAX_EFFECTS  (EFFECT_SLOTS),
    .SAMPLE_FRAMES(FRAME_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch),
    .out_o (res_ch)
  );

  // Predicted sample memory and voice slots.
  logic [31:0]          frame_mem    [FRAME_DEPTH];
  bit                   frame_loaded [FRAME_DEPTH];
  bit                   voice_on     [VOICE_SLOTS];
  logic [ADDR_IN_W-1:0] voice_base   [VOICE_SLOTS];
  logic [FRAMES_W-1:0]  voice_len    [VOICE_SLOTS];
  logic [FRAMES_W-1:0]  voice_pos    [VOICE_SLOTS];
  logic [GAIN_W-1:0]    voice_gain   [VOICE_SLOTS];
  bit                   voice_loop   [VOICE_SLOTS];

  mix_res_t    mix_expect_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_count  = 0;
  bit          calm_mode   = 1'b0;

  // Clock.
  always #10 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_voice_pcm_mixer_tb: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Q1.15 scaling; signed integer division already truncates toward zero.
  function automatic int signed apply_gain(logic signed [SAMPLE_W-1:0] smp,
                                           logic [GAIN_W-1:0] g);
    int signed prod;
    prod = int'(smp) * int'(g);
    return prod / 32768;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp16(int signed v);
    if (v > int'(SAT_MAX)) return SAT_MAX;
    if (v < int'(SAT_MIN)) return SAT_MIN;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic void clear_voice(int unsigned i);
    voice_on[i]   = 1'b0;
    voice_base[i] = '0;
    voice_len[i]  = '0;
    voice_pos[i]  = '0;
    voice_gain[i] = '0;
    voice_loop[i] = 1'b0;
  endfunction

  // Appends one predicted result at the tail of the expected queue.
  function automatic void expect_put(mix_res_t item);
    mix_expect_q = {mix_expect_q, item};
  endfunction

  // Advances the predicted mixer state by one request and returns its result.
  function automatic mix_res_t mix_predict(mix_req_t r);
    mix_res_t             res;
    int signed            acc_l;
    int signed            acc_r;
    int                   pick;
    int                   i;
    int unsigned          voices;
    logic [FRAMES_W-1:0]  frames;
    logic [GAIN_W-1:0]    g;
    logic [31:0]          frm;
    logic [ADDR_IN_W-1:0] addr;
    acc_l      = 0;
    acc_r      = 0;
    res.status = STATUS_OK;
    case (r.req_type)
      REQ_LOAD: begin
        frame_mem[r.mem_addr]    = {r.load_right, r.load_left};
        frame_loaded[r.mem_addr] = 1'b1;
      end
      REQ_START: begin
        frames = (r.sound_frames > MAX_LENGTH) ? MAX_LENGTH : r.sound_frames;
        g      = (r.gain > UNITY_GAIN) ? UNITY_GAIN : r.gain;
        pick   = -1;
        if (frames == 0) begin
          res.status = STATUS_EMPTY;
        end else if (r.music_slot) begin
          pick = MUSIC_SLOT;
        end else begin
          for (i = 0; i < EFFECT_SLOTS && pick < 0; i++) begin
            if (!voice_on[i]) pick = i;
          end
          if (pick < 0) res.status = STATUS_FULL;
        end
        if (pick >= 0) begin
          voice_on[pick]   = 1'b1;
          voice_base[pick] = r.mem_addr;
          voice_len[pick]  = frames;
          voice_pos[pick]  = '0;
          voice_gain[pick] = g;
          voice_loop[pick] = r.repeat_flag;
        end
      end
      REQ_TICK: begin
        // Effects first in index order, the music slot last.
        for (i = 0; i < VOICE_SLOTS; i++) begin
          if (voice_on[i]) begin
            addr  = voice_base[i] + voice_pos[i][ADDR_IN_W-1:0];
            frm   = frame_mem[addr];
            acc_l += apply_gain(frm[15:0], voice_gain[i]);
            acc_r += apply_gain(frm[31:16], voice_gain[i]);
            voice_pos[i] = voice_pos[i] + 1'b1;
            if (voice_pos[i] >= voice_len[i]) begin
              if (voice_loop[i]) voice_pos[i] = '0;
              else clear_voice(i);
            end
          end
        end
      end
      default: begin
        for (i = 0; i < VOICE_SLOTS; i++) clear_voice(i);
      end
    endcase
    voices = 0;
    for (i = 0; i < VOICE_SLOTS; i++) voices += voice_on[i];
    res.mix_left      = clamp16(acc_l);
    res.mix_right     = clamp16(acc_r);
    res.active_voices = voices[VOICES_W-1:0];
    return res;
  endfunction

  // A request of the given kind with random content in every field.
  function automatic mix_req_t noise_req(logic [1:0] kind);
    mix_req_t r;
    r.req_type     = kind;
    r.mem_addr     = ADDR_IN_W'($urandom);
    r.load_left    = SAMPLE_W'($urandom);
    r.load_right   = SAMPLE_W'($urandom);
    r.sound_frames = FRAMES_W'($urandom);
    r.gain         = GAIN_W'($urandom);
    r.repeat_flag  = 1'($urandom);
    r.music_slot   = 1'($urandom);
    return r;
  endfunction

  // Sends one request beat and records its predicted result on acceptance.
  task automatic send_req(input mix_req_t r);
    int unsigned gap;
    gap = calm_mode ? 0 : $urandom_range(13, 0);
    if (gap > 0) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_ch.req_type     <= r.req_type;
    req_ch.mem_addr     <= r.mem_addr;
    req_ch.load_left    <= r.load_left;
    req_ch.load_right   <= r.load_right;
    req_ch.sound_frames <= r.sound_frames;
    req_ch.gain         <= r.gain;
    req_ch.repeat_flag  <= r.repeat_flag;
    req_ch.music_slot   <= r.music_slot;
    req_ch.valid        <= 1'b1;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    expect_put(mix_predict(r));
    sent_count++;
  endtask

  task automatic send_load(input logic [ADDR_IN_W-1:0] addr,
                           input logic signed [SAMPLE_W-1:0] left,
                           input logic signed [SAMPLE_W-1:0] right);
    mix_req_t r;
    r            = noise_req(REQ_LOAD);
    r.mem_addr   = addr;
    r.load_left  = left;
    r.load_right = right;
    send_req(r);
  endtask

  task automatic send_start(input logic [ADDR_IN_W-1:0] base,
                            input logic [FRAMES_W-1:0] frames,
                            input logic [GAIN_W-1:0] g,
                            input logic loop_on, input logic to_music);
    mix_req_t r;
    r              = noise_req(REQ_START);
    r.mem_addr     = base;
    r.sound_frames = frames;
    r.gain         = g;
    r.repeat_flag  = loop_on;
    r.music_slot   = to_music;
    send_req(r);
  endtask

  // Loads any frame that an active voice is about to read, then ticks.
  task automatic send_tick();
    logic [ADDR_IN_W-1:0] addr;
    int                   i;
    for (i = 0; i < VOICE_SLOTS; i++) begin
      if (voice_on[i]) begin
        addr = voice_base[i] + voice_pos[i][ADDR_IN_W-1:0];
        if (!frame_loaded[addr]) begin
          send_load(addr, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end
      end
    end
    send_req(noise_req(REQ_TICK));
  endtask

  // Result side: random stall before each beat, then hold ready until it moves.
  initial begin
    int unsigned stall;
    res_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = calm_mode ? 0 : $urandom_range(13, 0);
      if (stall > 0) begin
        @(negedge clk_i);
        res_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
    end
  end

  // Compare each result beat against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    mix_res_t want;
    if (rst_ni === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (mix_expect_q.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = mix_expect_q.pop_front();
        if (res_ch.mix_left !== want.mix_left)
          report_mismatch("mix_left", int'(res_ch.mix_left), int'(want.mix_left));
        if (res_ch.mix_right !== want.mix_right)
          report_mismatch("mix_right", int'(res_ch.mix_right), int'(want.mix_right));
        if (res_ch.status !== want.status)
          report_mismatch("status", int'(res_ch.status), int'(want.status));
        if (res_ch.active_voices !== want.active_voices)
          report_mismatch("active_voices", int'(res_ch.active_voices),
                          int'(want.active_voices));
      end
    end
  end

  // Full-scale frames at both ends of the address range, and a small
  // negative sample whose scaled value truncates toward zero.
  task automatic test_load_extremes();
    send_load(16'h0000, 16'sh8000, 16'sh7FFF);
    send_load(16'hFFFF, 16'sh7FFF, 16'sh8000);
    send_load(16'h0001, -16'sd1, 16'sd1);
  endtask

  // A zero-length sound is rejected for effects and for music alike.
  task automatic test_empty_sounds();
    send_start(16'h1234, '0, UNITY_GAIN, 1'b1, 1'b0);
    send_start(16'h4321, '0, UNITY_GAIN, 1'b0, 1'b1);
  endtask

  // Fill every effect slot, overflow it, saturate the mix in both directions,
  // wrap a looping music sound across the top of memory, then replace it.
  task automatic test_slot_exhaustion();
    int                  i;
    logic [FRAMES_W-1:0] frames;
    logic [GAIN_W-1:0]   g;
    send_start(16'hFFFF, 17'd2, 16'hFFFF, 1'b1, 1'b1);
    for (i = 0; i < EFFECT_SLOTS; i++) begin
      frames = (i == 0) ? 17'h1FFFF : (i == 1) ? MAX_LENGTH : 17'd4;
      g      = (i == 3) ? 16'h0000 : (i == 5) ? 16'hFFFF : UNITY_GAIN;
      send_start(16'h0000, frames, g, 1'b0, 1'b0);
    end
    send_start(16'h0000, 17'd4, UNITY_GAIN, 1'b0, 1'b0);
    repeat (3) send_tick();
    send_start(16'h0001, 17'd1, 16'h4000, 1'b0, 1'b1);
  endtask

  // Stop clears every slot; a following tick mixes silence.
  task automatic test_stop_all();
    send_req(noise_req(REQ_STOP));
    send_tick();
  endtask

  // Random mix of loads, starts, ticks and stops with random gaps, until
  // about RANDOM_ITEMS request beats have been sent in the whole run.
  task automatic test_random_traffic();
    int unsigned          n;
    int unsigned          pick;
    int unsigned          k;
    logic [ADDR_IN_W-1:0] base;
    logic [FRAMES_W-1:0]  frames;
    for (n = 0; sent_count < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) calm_mode = ($urandom_range(3, 0) == 0);
      pick = $urandom_range(99, 0);
      if (pick < 10) begin
        send_load(ADDR_IN_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      end else if (pick < 45) begin
        // Bases mostly come from a few small windows, one wrapping past the top.
        case ($urandom_range(3, 0))
          0:       base = ADDR_IN_W'($urandom_range(255, 0));
          1:       base = ADDR_IN_W'(16'h7F00 + $urandom_range(255, 0));
          2:       base = ADDR_IN_W'(16'hFF80 + $urandom_range(255, 0));
          default: base = ADDR_IN_W'($urandom);
        endcase
        k = $urandom_range(99, 0);
        if (k < 5)       frames = '0;
        else if (k < 90) frames = FRAMES_W'($urandom_range(12, 1));
        else if (k < 96) frames = FRAMES_W'($urandom_range(65536, 13));
        else             frames = FRAMES_W'($urandom_range(131071, 65537));
        send_start(base, frames, GAIN_W'($urandom), 1'($urandom),
                   $urandom_range(99, 0) < 15);
      end else if (pick < 97) begin
        send_tick();
      end else begin
        send_req(noise_req(REQ_STOP));
      end
    end
    calm_mode = 1'b0;
  endtask

  // Reset, run the tests in turn, drain and report.
  initial begin
    rst_ni              = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_LOAD;
    req_ch.mem_addr     = '0;
    req_ch.load_left    = '0;
    req_ch.load_right   = '0;
    req_ch.sound_frames = '0;
    req_ch.gain         = '0;
    req_ch.repeat_flag  = 1'b0;
    req_ch.music_slot   = 1'b0;
    for (int i = 0; i < VOICE_SLOTS; i++) clear_voice(i);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_load_extremes();
    test_empty_sounds();
    test_slot_exhaustion();
    test_stop_all();
    test_random_traffic();

    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (mix_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mix_expect_q.size() != 0)
      report_mismatch("results still expected", 0, mix_expect_q.size());

    if (error_count == 0) begin
      $display("multi_voice_pcm_mixer_tb: done, clean");
    end else begin
      $display("multi_voice_pcm_mixer_tb: done, errors");
    end
    $finish;
  end

endmodule
